@@ rtl/matrix_keypad_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Matrix keypad scanner assertion macros
// Clocked, reset-qualified property shorthands for the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("matrix keypad scanner: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define MKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("matrix keypad scanner: next-cycle check failed");

`endif

@@ rtl/mks_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix keypad scanner package
// Geometry constants, scan phase type and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

    // Key matrix geometry
    localparam int ROWS    = 3;   // 1 .. 15
    localparam int COLUMNS = 7;   // 1 .. 8

    // Field widths
    localparam int COL_W   = 8;
    localparam int DRIVE_W = 15;
    localparam int CODE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int DEB_W   = 20;

    localparam int CODE_ROW_SHIFT = 4;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = DEB_W'(10000);
    localparam logic [COL_W-1:0]   COL_MASK       = COL_W'((1 << COLUMNS) - 1);
    localparam logic [DRIVE_W-1:0] ROW_MASK       = DRIVE_W'((1 << ROWS) - 1);
    localparam logic [DRIVE_W-1:0] IDLE_DRIVE     = ~ROW_MASK;
    localparam logic [IDX_W-1:0]   ROWS_C         = IDX_W'(ROWS);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_SCAN = 2'd2
    } t_phase;

    typedef struct packed {
        logic [DRIVE_W-1:0] row_drive;
        logic               scan_done;
        logic [CODE_W-1:0]  key_code;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/mks_if.sv @@
// ----------------------------------------------------------------------------
// Matrix keypad scanner channels
// Column sample channel and scan result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mks_col_if;
    logic                      valid;
    logic                      ready;
    logic [mks_pkg::COL_W-1:0] column_levels;

    modport source (output valid, output column_levels, input ready);
    modport sink   (input valid, input column_levels, output ready);
endinterface

interface mks_res_if;
    logic                        valid;
    logic                        ready;
    logic [mks_pkg::DRIVE_W-1:0] row_drive;
    logic                        scan_done;
    logic [mks_pkg::CODE_W-1:0]  key_code;

    modport source (output valid, output row_drive, output scan_done, output key_code,
                    input ready);
    modport sink   (input valid, input row_drive, input scan_done, input key_code,
                     output ready);
endinterface

`default_nettype wire

@@ rtl/matrix_keypad_scanner.sv @@
// ----------------------------------------------------------------------------
// Matrix keypad scanner
// Active-low key matrix scanner with debounce, one column sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_col carries one sample of the column lines per transfer. Every sample
//   yields exactly one result on o_res: the row drive to apply before the
//   next sample, a scan_done flag and the key code (row << 4 | column, both
//   from 1, zero for no key or when no scan finished).
//   A result is registered on its sample transfer and stays in the
//   output register until taken. A new sample is taken in every cycle in
//   which the output register is empty or being emptied, so the sustained
//   rate is one sample per cycle; the scan state update and the result
//   register sit in a single loop.
//   When the receiver stalls, i_col.ready drops and the scan state holds.
//   Reset (synchronous, active low) returns the scanner to idle, empties
//   the output register and sets the debounce
//   length to 10000 ticks. Write the length through i_cfg_wr_en and
//   i_cfg_wr_data only while no sample or result is in flight; a write
//   during a debounce wait applies from the next sample on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_keypad_scanner_macros.svh"

module matrix_keypad_scanner (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [mks_pkg::DEB_W-1:0] i_cfg_wr_data,
    mks_col_if.sink                        i_col,
    mks_res_if.source                      o_res
);

    mks_pkg::t_result w_result;
    mks_pkg::t_result r_res;
    logic             r_out_valid;
    logic             w_in_ready;
    logic             w_accept;

    // Take a sample when the result slot is free or being freed
    assign w_in_ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_col.valid && w_in_ready;
    assign i_col.ready = w_in_ready;

    mks_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_accept        (w_accept),
        .i_column_levels (i_col.column_levels),
        .o_result        (w_result)
    );

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload on each input transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_result;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.row_drive = r_res.row_drive;
    assign o_res.scan_done = r_res.scan_done;
    assign o_res.key_code  = r_res.key_code;

    // A key code only comes with a finished scan
    `MKS_ASSERT_SAME(a_code_needs_done, i_clk, i_rst_n,
        r_out_valid && (r_res.key_code != '0), r_res.scan_done)
    // A finished scan always leaves all rows driven low
    `MKS_ASSERT_SAME(a_done_goes_idle, i_clk, i_rst_n,
        r_out_valid && r_res.scan_done, r_res.row_drive == mks_pkg::IDLE_DRIVE)
    // A full, stalled result register blocks new samples
    `MKS_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n,
        r_out_valid && !o_res.ready, !w_accept)
    // Every sample transfer produces a pending result
    `MKS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, r_out_valid)

endmodule

`default_nettype wire

@@ rtl/mks_ctrl.sv @@
// ----------------------------------------------------------------------------
// Matrix keypad scanner control
// Scan state machine: debounce wait, resample, row walk and key code.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mks_pkg::DEB_W-1:0]     i_cfg_wr_data,
    input  wire logic                          i_accept,
    input  wire logic [mks_pkg::COL_W-1:0]     i_column_levels,
    output mks_pkg::t_result                   o_result
);

    mks_pkg::t_phase               r_phase, n_phase;
    logic [mks_pkg::IDX_W-1:0]     r_row, n_row;
    logic [mks_pkg::IDX_W-1:0]     r_col, n_col;
    logic [mks_pkg::DEB_W-1:0]     r_wait, n_wait;
    logic [mks_pkg::DEB_W-1:0]     r_debounce;

    logic [mks_pkg::COL_W-1:0]     w_low;
    logic                          w_single;
    logic [mks_pkg::IDX_W-1:0]     w_low_idx;
    logic [mks_pkg::IDX_W-1:0]     w_row_inc;

    // Pressed columns, and the number (from 1) of a single pressed column
    always_comb begin
        w_low     = ~i_column_levels & mks_pkg::COL_MASK;
        w_single  = (w_low != '0) && ((w_low & (w_low - 1'b1)) == '0);
        w_low_idx = '0;
        for (int i = 0; i < mks_pkg::COLUMNS; i++) begin
            if (w_low[i]) begin
                w_low_idx = w_low_idx | mks_pkg::IDX_W'(i + 1);
            end
        end
        w_row_inc = r_row + 1'b1;
    end

    // Next state and result for the current sample
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_col   = r_col;
        n_wait  = r_wait;
        o_result.scan_done = 1'b0;
        o_result.key_code  = '0;

        unique case (r_phase)
            mks_pkg::PH_WAIT: begin
                if (r_wait >= r_debounce) begin
                    if (w_single) begin
                        n_col   = w_low_idx;
                        n_row   = '0;
                        n_phase = mks_pkg::PH_SCAN;
                    end else begin
                        o_result.scan_done = 1'b1;
                        n_phase = mks_pkg::PH_IDLE;
                    end
                    n_wait = '0;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            mks_pkg::PH_SCAN: begin
                if (w_low != '0) begin
                    o_result.scan_done = 1'b1;
                    o_result.key_code  = {w_row_inc, r_col};
                    n_phase = mks_pkg::PH_IDLE;
                end else if (w_row_inc >= mks_pkg::ROWS_C) begin
                    o_result.scan_done = 1'b1;
                    n_phase = mks_pkg::PH_IDLE;
                    n_row   = '0;
                end else begin
                    n_row = w_row_inc;
                end
            end
            default: begin
                n_phase = mks_pkg::PH_IDLE;
                if (w_low != '0) begin
                    n_phase = mks_pkg::PH_WAIT;
                    n_wait  = '0;
                end
            end
        endcase

        // Drive one row low while scanning, all rows low otherwise
        if (n_phase == mks_pkg::PH_SCAN) begin
            o_result.row_drive = ~(mks_pkg::DRIVE_W'(1) << n_row);
        end else begin
            o_result.row_drive = mks_pkg::IDLE_DRIVE;
        end
    end

    // Advance scan state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mks_pkg::PH_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_wait  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_wait  <= n_wait;
        end
    end

    // Hold the debounce length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= mks_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_wr_en) begin
            r_debounce <= i_cfg_wr_data;
        end
    end

endmodule

`default_nettype wire
